>>> hdl/bha_pkg.sv
`timescale 1ns / 1ps

package bha_pkg;

	localparam int HANDLE_W  = 16;
	localparam int WORD_BITS = 64;
	localparam int WORD_LOG2 = 6;
	localparam int NBYTES    = WORD_BITS / 8;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RESERVE = 2'd1,
		OP_FREE    = 2'd2,
		OP_QUERY   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_BAD_PRIMARY   = 3'd1,
		ST_BAD_SECONDARY = 3'd2,
		ST_NONE_FREE     = 3'd3,
		ST_ALREADY       = 3'd4,
		ST_NEVER_USED    = 3'd5,
		ST_NOT_ALLOC     = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CFG_PRIMARY = 2'd0,
		CFG_SEC_LOW = 2'd1,
		CFG_SEC_HIGH = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_READ,
		S_SCAN,
		S_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic    clear_en;
		logic    capture;
		logic    single_read;
		logic    scan_start;
		logic    scan_stop;
		logic    set_active;
		logic    wr_set;
		logic    wr_clr;
		logic    wr_alloc;
		logic    res_load;
		status_t res_status;
		logic    res_alloc;
		logic    res_used;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  prim_ok;
		logic  sec_ok;
		logic  range_empty;
		logic  active;
		logic  bit_set;
		logic  s2_valid;
		logic  s2_found;
		logic  s2_last;
		logic  clear_last;
		logic  out_free;
	} sts_t;

endpackage

>>> hdl/bha_ram.sv
`timescale 1ns / 1ps

module bha_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/bha_ctrl.sv
`timescale 1ns / 1ps

module bha_ctrl
	import bha_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!sts.prim_ok) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_BAD_PRIMARY;
					state_d = S_FINISH;
				end else if (sts.kind == OP_ALLOC) begin
					cmd.set_active = 1'b1;
					if (sts.range_empty) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_NONE_FREE;
						state_d = S_FINISH;
					end else begin
						cmd.scan_start = 1'b1;
						state_d = S_SCAN;
					end
				end else if (!sts.sec_ok) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_BAD_SECONDARY;
					state_d = S_FINISH;
				end else begin
					cmd.single_read = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.res_load = 1'b1;
				state_d = S_FINISH;
				case (sts.kind)
					OP_RESERVE: begin
						cmd.set_active = 1'b1;
						if (sts.bit_set) begin
							cmd.res_status = ST_ALREADY;
						end else begin
							cmd.wr_set = 1'b1;
						end
					end
					OP_FREE: begin
						if (!sts.active) begin
							cmd.res_status = ST_NEVER_USED;
						end else if (!sts.bit_set) begin
							cmd.res_status = ST_NOT_ALLOC;
						end else begin
							cmd.wr_clr = 1'b1;
						end
					end
					default: begin
						cmd.res_used = sts.active & sts.bit_set;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.s2_valid && sts.s2_found) begin
					cmd.wr_alloc  = 1'b1;
					cmd.res_load  = 1'b1;
					cmd.res_alloc = 1'b1;
					cmd.scan_stop = 1'b1;
					state_d = S_FINISH;
				end else if (sts.s2_valid && sts.s2_last) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_NONE_FREE;
					cmd.scan_stop  = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a result not yet taken");

	a_read_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> $past(cmd.single_read))
		else $error("read data used without a read issued");

endmodule

>>> hdl/bha_dp.sv
`timescale 1ns / 1ps

module bha_dp
	import bha_pkg::*;
#(
	parameter int HANDLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] s_tdata,
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  cmd_t        cmd,
	output sts_t        sts
);

	localparam int NWORDS = (HANDLE_BITS > WORD_LOG2) ? (1 << (HANDLE_BITS - WORD_LOG2)) : 1;
	localparam int ADDR_BITS = (HANDLE_BITS > WORD_LOG2) ? (HANDLE_BITS - WORD_LOG2) : 1;
	localparam logic [HANDLE_W-1:0] HMAX = HANDLE_W'((32'd1 << HANDLE_BITS) - 32'd1);
	localparam logic [ADDR_BITS-1:0] LAST_WORD = ADDR_BITS'(NWORDS - 1);

	logic [HANDLE_W-1:0] primary_handle_q, secondary_low_q, secondary_high_q;
	kind_t               kind_q;
	logic [HANDLE_W-1:0] prim_q, sec_q;
	logic                active_q;
	logic [ADDR_BITS-1:0] clr_addr_q;

	logic [HANDLE_W-1:0] lo_c, hi_c;
	logic [ADDR_BITS-1:0] lo_word, hi_word, sec_word;

	logic                 issue_q;
	logic [ADDR_BITS-1:0] scan_addr_q;
	logic                 valid_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic                 valid_s2, last_s2;
	logic [ADDR_BITS-1:0] addr_s2;
	logic [WORD_BITS-1:0] word_s2;
	logic [NBYTES-1:0]    byte_any_s2;
	logic [2:0]           byte_idx_s2 [NBYTES];

	logic [WORD_BITS-1:0] rd_data, wr_data;
	logic [ADDR_BITS-1:0] rd_addr, wr_addr;
	logic                 rd_en, wr_en;

	logic [WORD_BITS-1:0] zero_s1;
	logic [NBYTES-1:0]    byte_any_s1;
	logic [2:0]           byte_idx_s1 [NBYTES];
	logic [2:0]           sel_byte;
	logic [WORD_LOG2-1:0] bit_s2;
	logic [HANDLE_W-1:0]  alloc_handle;

	status_t             res_status_q;
	logic [HANDLE_W-1:0] res_hp_q, res_hs_q;
	logic                res_used_q;
	logic                m_tvalid_q;
	logic [39:0]         m_tdata_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_handle_q <= 16'd1;
			secondary_low_q  <= 16'd1;
			secondary_high_q <= 16'hffff;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRIMARY:  primary_handle_q <= cfg_data;
				CFG_SEC_LOW:  secondary_low_q  <= cfg_data;
				CFG_SEC_HIGH: secondary_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective range: handle 0 is never valid, and the top is clipped to the handle space.
	assign lo_c     = (secondary_low_q == '0) ? HANDLE_W'(1) : secondary_low_q;
	assign hi_c     = (secondary_high_q > HMAX) ? HMAX : secondary_high_q;
	assign lo_word  = ADDR_BITS'(lo_c >> WORD_LOG2);
	assign hi_word  = ADDR_BITS'(hi_c >> WORD_LOG2);
	assign sec_word = ADDR_BITS'(sec_q >> WORD_LOG2);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind_t'(s_tuser[1:0]);
			sec_q  <= s_tdata[31:16];
			if (kind_t'(s_tuser[1:0]) == OP_ALLOC && !s_tuser[2]) begin
				prim_q <= primary_handle_q;
			end else begin
				prim_q <= s_tdata[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.set_active) begin
				active_q <= 1'b1;
			end
			if (cmd.clear_en) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Scan pipeline: issue a word read per cycle, mask and search bytes, then pick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (cmd.scan_start) begin
			issue_q  <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.scan_stop || (issue_q && scan_addr_q == hi_word)) begin
				issue_q <= 1'b0;
			end
			valid_s1 <= issue_q & ~cmd.scan_stop;
			valid_s2 <= valid_s1 & ~cmd.scan_stop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_addr_q <= lo_word;
		end else if (issue_q) begin
			scan_addr_q <= scan_addr_q + 1'b1;
		end
		addr_s1     <= scan_addr_q;
		addr_s2     <= addr_s1;
		last_s2     <= (addr_s1 == hi_word);
		word_s2     <= rd_data;
		byte_any_s2 <= byte_any_s1;
		byte_idx_s2 <= byte_idx_s1;
	end

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			zero_s1[j] = ~rd_data[j]
				& ~((addr_s1 == lo_word) && (WORD_LOG2'(j) < lo_c[WORD_LOG2-1:0]))
				& ~((addr_s1 == hi_word) && (WORD_LOG2'(j) > hi_c[WORD_LOG2-1:0]));
		end
		for (int k = 0; k < NBYTES; k++) begin
			byte_any_s1[k] = |zero_s1[k*8 +: 8];
			byte_idx_s1[k] = 3'd0;
			for (int b = 7; b >= 0; b--) begin
				if (zero_s1[k*8 + b]) begin
					byte_idx_s1[k] = 3'(b);
				end
			end
		end
	end

	always_comb begin
		sel_byte = 3'd0;
		for (int k = NBYTES - 1; k >= 0; k--) begin
			if (byte_any_s2[k]) begin
				sel_byte = 3'(k);
			end
		end
	end

	assign bit_s2       = {sel_byte, byte_idx_s2[sel_byte]};
	assign alloc_handle = HANDLE_W'({addr_s2, bit_s2});

	// Memory port selection.
	always_comb begin
		rd_en   = issue_q | cmd.single_read;
		rd_addr = issue_q ? scan_addr_q : sec_word;
		wr_en   = cmd.clear_en | cmd.wr_set | cmd.wr_clr | cmd.wr_alloc;
		wr_addr = sec_word;
		wr_data = rd_data | (WORD_BITS'(1) << sec_q[WORD_LOG2-1:0]);
		if (cmd.clear_en) begin
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (cmd.wr_alloc) begin
			wr_addr = addr_s2;
			wr_data = word_s2 | (WORD_BITS'(1) << bit_s2);
		end else if (cmd.wr_clr) begin
			wr_data = rd_data & ~(WORD_BITS'(1) << sec_q[WORD_LOG2-1:0]);
		end
	end

	bha_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NWORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_used_q   <= cmd.res_used;
			res_hp_q     <= cmd.res_alloc ? primary_handle_q : '0;
			res_hs_q     <= cmd.res_alloc ? alloc_handle : '0;
		end
		if (cmd.out_load) begin
			m_tdata_q <= {4'd0, res_used_q, res_hs_q, res_hp_q, res_status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		sts.kind        = kind_q;
		sts.prim_ok     = (prim_q == primary_handle_q);
		sts.sec_ok      = (sec_q >= lo_c) && (sec_q <= hi_c);
		sts.range_empty = (lo_c > hi_c);
		sts.active      = active_q;
		sts.bit_set     = rd_data[sec_q[WORD_LOG2-1:0]];
		sts.s2_valid    = valid_s2;
		sts.s2_found    = |byte_any_s2;
		sts.s2_last     = last_s2;
		sts.clear_last  = (clr_addr_q == LAST_WORD);
		sts.out_free    = ~m_tvalid_q | m_tready;
	end

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_en, cmd.wr_set, cmd.wr_clr, cmd.wr_alloc}))
		else $error("more than one source drives the bitmap write port");

	a_alloc_free_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_alloc |-> !word_s2[bit_s2])
		else $error("allocate picked a bit that was already set");

	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_alloc |-> (alloc_handle >= lo_c && alloc_handle <= hi_c))
		else $error("allocated handle lies outside the secondary range");

endmodule

>>> hdl/bitmap_handle_allocator_core.sv
`timescale 1ns / 1ps

// Secondary handle allocator for one configured primary handle.
// Requests arrive on the s_ channel: tuser holds the operation kind and the
// primary-given flag, tdata the primary and secondary handles. Each request
// yields exactly one response transaction on the m_ channel with a status
// code, the allocated handle pair and the query answer.
// The allocation bitmap lives in a RAM of 2^HANDLE_BITS/64 words of 64 bits.
// Reserve, free and query pass from acceptance to the response through capture,
// range check and word read, then the result register loads the output.
// Allocate reads one bitmap word per cycle from the word holding the low end
// of the range, through a two-stage search pipeline.
// One request is handled at a time; the next is taken as soon as the
// response sits in the output register, even while the receiver stalls.
// After reset the block sweeps the bitmap RAM clear, one word per cycle,
// with s_tready low; configuration writes are taken during that sweep.
// Configuration is written while idle.
module bitmap_handle_allocator_core
	import bha_pkg::*;
#(
	parameter int HANDLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // primary [15:0], secondary [31:16]
	input  logic [2:0]  s_tuser,  // kind [1:0], primary_given [2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // status [2:0], handle_primary [18:3],
	                              // handle_secondary [34:19], in_use [35]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	bha_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bha_dp #(
		.HANDLE_BITS(HANDLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

>>> bench/tb_bitmap_handle_allocator_core.sv
`timescale 1ns / 1ps

module tb_bitmap_handle_allocator_core;
	import bha_pkg::*;

	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 70;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_WAIT  = 1040;

	typedef struct packed {
		logic [3:0]  pad;
		logic        in_use;
		logic [15:0] handle_secondary;
		logic [15:0] handle_primary;
		status_t     status;
	} resp_t;

	typedef struct packed {
		logic        is_cfg;
		cfg_index_t  idx;
		logic [15:0] val;
		kind_t       kind;
		logic        given;
		logic [15:0] prim;
		logic [15:0] sec;
		logic        fixed;
		resp_t       exp;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // primary [15:0], secondary [31:16]
	logic [2:0]  s_tuser;  // kind [1:0], primary_given [2]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // status [2:0], handle_primary [18:3],
	                       // handle_secondary [34:19], in_use [35]
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// Mirror of the allocator state and its registers.
	bit          taken_map [0:65535];
	bit          prim_active;
	logic [15:0] reg_prim;
	logic [15:0] reg_lo;
	logic [15:0] reg_hi;

	resp_t       pending_responses [$];
	dir_row_t    dir_table [$];
	logic        req_fixed;
	resp_t       req_fixed_resp;
	bit          hold_off_req = 1'b0;
	int          fail_count = 0;
	int          sent_count = 0;
	int          checked_count = 0;
	int          write_count = 0;
	int          status_hist [0:7];
	resp_t       got_resp;
	resp_t       want_resp;

	bitmap_handle_allocator_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic resp_t allocator_response(kind_t k, logic given, logic [15:0] prim,
			logic [15:0] sec);
		resp_t       r;
		int          lo;
		int          hi;
		int          h;
		logic [15:0] p;
		r = '0;
		r.status = ST_OK;
		lo = (reg_lo < 16'd1) ? 1 : int'(reg_lo);
		hi = int'(reg_hi);
		p = prim;
		if (k == OP_ALLOC) begin
			if (!given)
				p = reg_prim;
			if (p != reg_prim) begin
				r.status = ST_BAD_PRIMARY;
			end else begin
				// A passing allocate activates the primary even if nothing is free.
				prim_active = 1'b1;
				h = lo;
				while (h <= hi && taken_map[h])
					h++;
				if (h <= hi) begin
					taken_map[h] = 1'b1;
					r.handle_primary = p;
					r.handle_secondary = h[15:0];
				end else begin
					r.status = ST_NONE_FREE;
				end
			end
		end else if (prim != reg_prim) begin
			r.status = ST_BAD_PRIMARY;
		end else if (int'(sec) < lo || int'(sec) > hi) begin
			r.status = ST_BAD_SECONDARY;
		end else begin
			case (k)
				OP_RESERVE: begin
					prim_active = 1'b1;
					if (taken_map[sec])
						r.status = ST_ALREADY;
					else
						taken_map[sec] = 1'b1;
				end
				OP_FREE: begin
					if (!prim_active)
						r.status = ST_NEVER_USED;
					else if (!taken_map[sec])
						r.status = ST_NOT_ALLOC;
					else
						taken_map[sec] = 1'b0;
				end
				default: begin
					r.in_use = prim_active && taken_map[sec];
				end
			endcase
		end
		return r;
	endfunction

	function automatic dir_row_t op_row(kind_t k, logic g, logic [15:0] p, logic [15:0] s);
		dir_row_t row;
		row = '0;
		row.kind = k;
		row.given = g;
		row.prim = p;
		row.sec = s;
		return row;
	endfunction

	function automatic dir_row_t op_fixed(kind_t k, logic g, logic [15:0] p, logic [15:0] s,
			status_t st, logic [15:0] hp, logic [15:0] hs, logic iu);
		dir_row_t row;
		row = op_row(k, g, p, s);
		row.fixed = 1'b1;
		row.exp.status = st;
		row.exp.handle_primary = hp;
		row.exp.handle_secondary = hs;
		row.exp.in_use = iu;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(cfg_index_t i, logic [15:0] v);
		dir_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.idx = i;
		row.val = v;
		return row;
	endfunction

	task automatic check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// Responses are checked before the request of the same edge is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_resp = m_tdata;
				if (pending_responses.size() == 0) begin
					$error("response transaction with nothing pending: %h", m_tdata);
					fail_count++;
				end else begin
					want_resp = pending_responses.pop_front();
					check_field("status", int'(want_resp.status), int'(got_resp.status));
					check_field("handle_primary", int'(want_resp.handle_primary),
						int'(got_resp.handle_primary));
					check_field("handle_secondary", int'(want_resp.handle_secondary),
						int'(got_resp.handle_secondary));
					check_field("in_use", int'(want_resp.in_use), int'(got_resp.in_use));
					status_hist[want_resp.status]++;
					checked_count++;
				end
			end
			if (s_tvalid && s_tready) begin
				want_resp = allocator_response(kind_t'(s_tuser[1:0]), s_tuser[2],
					s_tdata[15:0], s_tdata[31:16]);
				if (req_fixed)
					want_resp = req_fixed_resp;
				pending_responses.push_back(want_resp);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: segments of steady, random or sparse readiness, plus one long hold-off.
	initial begin : receiver
		int seg;
		int mode;
		int cnt;
		m_tready = 1'b0;
		forever begin
			if (hold_off_req) begin
				@(negedge clk);
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				seg = $urandom_range(4, 40);
				mode = $urandom_range(0, 2);
				cnt = 0;
				while (cnt < seg && !hold_off_req) begin
					@(negedge clk);
					case (mode)
						0: m_tready = 1'b1;
						1: m_tready = 1'($urandom_range(0, 1));
						default: m_tready = ($urandom_range(0, 3) == 0);
					endcase
					cnt++;
				end
			end
		end
	end

	task automatic send_request(kind_t k, logic given, logic [15:0] prim, logic [15:0] sec,
			logic fixed, resp_t exp);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {sec, prim};
		s_tuser = {given, k};
		req_fixed = fixed;
		req_fixed_resp = exp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic idle_gap(int n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			CFG_PRIMARY: reg_prim = val;
			CFG_SEC_LOW: reg_lo = val;
			default: reg_hi = val;
		endcase
		write_count++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_setting(logic [15:0] p, logic [15:0] lo, logic [15:0] hi);
		settle();
		write_reg(CFG_PRIMARY, p);
		write_reg(CFG_SEC_LOW, lo);
		write_reg(CFG_SEC_HIGH, hi);
	endtask

	// Mostly the configured primary and secondaries near the active range.
	task automatic send_random(int f_lo, int f_hi);
		int          r;
		kind_t       k;
		logic        g;
		logic [15:0] p;
		logic [15:0] s;
		k = kind_t'($urandom_range(0, 3));
		g = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 9);
		if (r < 7)
			p = reg_prim;
		else if (r < 9)
			p = 16'($urandom_range(0, 65535));
		else
			p = reg_prim ^ (16'd1 << $urandom_range(0, 15));
		r = $urandom_range(0, 9);
		if (r < 6)
			s = 16'($urandom_range(f_lo, f_hi));
		else if (r == 6)
			s = 16'h0000;
		else if (r == 7)
			s = 16'hffff;
		else
			s = 16'($urandom_range(0, 65535));
		send_request(k, g, p, s, 1'b0, '0);
	endtask

	initial begin : stimulus
		int ph;
		int n;
		int blen;
		int p;
		int lo;
		int hi;
		int mn;
		int mx;
		int f_lo;
		int f_hi;
		bit hold_done;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_PRIMARY;
		cfg_data = '0;
		arst_n = 1'b0;
		req_fixed = 1'b0;
		req_fixed_resp = '0;
		prim_active = 1'b0;
		reg_prim = 16'd1;
		reg_lo = 16'd1;
		reg_hi = 16'hffff;
		hold_done = 1'b0;
		foreach (status_hist[i])
			status_hist[i] = 0;

		// Before any use, then with an empty range, then the range edges.
		dir_table.push_back(op_fixed(OP_QUERY, 1'b0, 16'd1, 16'd5, ST_OK, 0, 0, 1'b0));
		dir_table.push_back(op_fixed(OP_RESERVE, 1'b1, 16'd0, 16'd5, ST_BAD_PRIMARY,
			0, 0, 1'b0));
		dir_table.push_back(op_fixed(OP_RESERVE, 1'b0, 16'd1, 16'd0, ST_BAD_SECONDARY,
			0, 0, 1'b0));
		dir_table.push_back(op_fixed(OP_FREE, 1'b0, 16'd1, 16'd5, ST_NEVER_USED, 0, 0, 1'b0));
		dir_table.push_back(cfg_row(CFG_SEC_LOW, 16'h0100));
		dir_table.push_back(cfg_row(CFG_SEC_HIGH, 16'h0080));
		dir_table.push_back(op_fixed(OP_ALLOC, 1'b0, 16'habcd, 16'h0000, ST_NONE_FREE,
			0, 0, 1'b0));
		dir_table.push_back(op_fixed(OP_QUERY, 1'b0, 16'd1, 16'h0090, ST_BAD_SECONDARY,
			0, 0, 1'b0));
		dir_table.push_back(cfg_row(CFG_SEC_LOW, 16'd1));
		dir_table.push_back(cfg_row(CFG_SEC_HIGH, 16'hffff));
		dir_table.push_back(op_fixed(OP_FREE, 1'b1, 16'd1, 16'd5, ST_NOT_ALLOC, 0, 0, 1'b0));
		dir_table.push_back(op_fixed(OP_ALLOC, 1'b0, 16'h5a5a, 16'hffff, ST_OK,
			16'd1, 16'd1, 1'b0));
		dir_table.push_back(op_fixed(OP_ALLOC, 1'b1, 16'hffff, 16'd0, ST_BAD_PRIMARY,
			0, 0, 1'b0));
		dir_table.push_back(op_fixed(OP_RESERVE, 1'b0, 16'd1, 16'hffff, ST_OK, 0, 0, 1'b0));
		dir_table.push_back(op_fixed(OP_RESERVE, 1'b1, 16'd1, 16'hffff, ST_ALREADY,
			0, 0, 1'b0));
		dir_table.push_back(op_fixed(OP_QUERY, 1'b0, 16'd1, 16'hffff, ST_OK, 0, 0, 1'b1));
		dir_table.push_back(op_fixed(OP_FREE, 1'b0, 16'd1, 16'hffff, ST_OK, 0, 0, 1'b0));
		dir_table.push_back(op_fixed(OP_FREE, 1'b0, 16'd1, 16'hffff, ST_NOT_ALLOC,
			0, 0, 1'b0));
		dir_table.push_back(op_row(OP_RESERVE, 1'b0, 16'd1, 16'd2));
		dir_table.push_back(op_row(OP_ALLOC, 1'b1, 16'd1, 16'h1234));
		dir_table.push_back(cfg_row(CFG_PRIMARY, 16'hffff));
		dir_table.push_back(op_row(OP_ALLOC, 1'b1, 16'hffff, 16'd0));
		dir_table.push_back(op_fixed(OP_QUERY, 1'b0, 16'd1, 16'd3, ST_BAD_PRIMARY,
			0, 0, 1'b0));
		dir_table.push_back(cfg_row(CFG_SEC_LOW, 16'hffff));
		dir_table.push_back(op_fixed(OP_ALLOC, 1'b0, 16'd0, 16'd0, ST_OK,
			16'hffff, 16'hffff, 1'b0));
		dir_table.push_back(op_fixed(OP_ALLOC, 1'b0, 16'd0, 16'd0, ST_NONE_FREE,
			0, 0, 1'b0));
		dir_table.push_back(op_row(OP_QUERY, 1'b1, 16'hffff, 16'hffff));
		dir_table.push_back(cfg_row(CFG_SEC_LOW, 16'd1));
		dir_table.push_back(cfg_row(CFG_PRIMARY, 16'd0));
		dir_table.push_back(op_row(OP_ALLOC, 1'b1, 16'd0, 16'h8000));
		dir_table.push_back(op_row(OP_FREE, 1'b0, 16'd0, 16'd1));
		dir_table.push_back(op_row(OP_ALLOC, 1'b0, 16'h7fff, 16'd0));

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_table[i]) begin
			if (dir_table[i].is_cfg) begin
				settle();
				write_reg(dir_table[i].idx, dir_table[i].val);
			end else begin
				send_request(dir_table[i].kind, dir_table[i].given, dir_table[i].prim,
					dir_table[i].sec, dir_table[i].fixed, dir_table[i].exp);
				if ($urandom_range(0, 1))
					idle_gap($urandom_range(1, 3));
			end
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			p = $urandom_range(0, 65535);
			case (ph)
				0, 7: begin
					lo = 1;
					hi = 65535;
				end
				1: begin
					lo = $urandom_range(1, 65000);
					hi = lo + $urandom_range(0, 40);
				end
				2: begin
					p = 65535;
					lo = 16'hffc0;
					hi = 65535;
				end
				3: begin
					// Low above high: nothing is in range.
					p = 0;
					lo = $urandom_range(16'h0200, 16'hfff0);
					hi = lo - $urandom_range(1, 16'h0100);
				end
				4: begin
					lo = 1;
					hi = 1;
				end
				5: begin
					lo = 1;
					hi = $urandom_range(2, 100);
				end
				default: begin
					lo = $urandom_range(1, 65535);
					hi = lo + $urandom_range(0, 200);
					if (hi > 65535)
						hi = 65535;
				end
			endcase
			apply_setting(16'(p), 16'(lo), 16'(hi));
			mn = (lo < hi) ? lo : hi;
			mx = (lo < hi) ? hi : lo;
			f_lo = (mn > 2) ? mn - 2 : 0;
			f_hi = (mx + 2 > 65535) ? 65535 : mx + 2;
			if (f_hi > f_lo + 100)
				f_hi = f_lo + 100;
			n = 0;
			while (n < PHASE_ITEMS) begin
				blen = $urandom_range(1, 16);
				if (ph == 1 && !hold_done) begin
					// Keep offering while the receiver holds off so the block backs up.
					hold_off_req = 1'b1;
					hold_done = 1'b1;
					blen = 24;
				end
				if (blen > PHASE_ITEMS - n)
					blen = PHASE_ITEMS - n;
				repeat (blen) begin
					send_random(f_lo, f_hi);
					n++;
				end
				if ($urandom_range(0, 3) != 0)
					idle_gap($urandom_range(1, 12));
			end
		end

		settle();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d requests under %0d register writes; %0d responses compared.",
			sent_count, write_count, checked_count);
		$display("Status mix: ok %0d, bad primary %0d, bad secondary %0d, none free %0d, %s",
			status_hist[ST_OK], status_hist[ST_BAD_PRIMARY], status_hist[ST_BAD_SECONDARY],
			status_hist[ST_NONE_FREE], $sformatf("already %0d, never used %0d, not alloc %0d.",
			status_hist[ST_ALREADY], status_hist[ST_NEVER_USED], status_hist[ST_NOT_ALLOC]));
		if (fail_count == 0 && pending_responses.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hdl/bha_pkg.sv
hdl/bha_ram.sv
hdl/bha_ctrl.sv
hdl/bha_dp.sv
hdl/bitmap_handle_allocator_core.sv
bench/tb_bitmap_handle_allocator_core.sv
